// File: rtl/core/mqtt_prp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_prp_pkg
// Shared types and constants for the MQTT PUBLISH receive parser: result
// kinds, drop reasons, size limits and the per-byte result descriptor.
// ----------------------------------------------------------------------------
package mqtt_prp_pkg;

  // result kinds
  localparam logic [2:0] KIND_TOPIC   = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  // drop reasons
  localparam logic [2:0] DROP_MALFORMED    = 3'd0;
  localparam logic [2:0] DROP_SHORT        = 3'd1;
  localparam logic [2:0] DROP_TOPIC_LONG   = 3'd2;
  localparam logic [2:0] DROP_NO_ID        = 3'd3;
  localparam logic [2:0] DROP_PAYLOAD_LONG = 3'd4;

  // size limits (a topic or payload must stay below these)
  localparam logic [16:0] TOPIC_LIMIT   = 17'd128;
  localparam logic [27:0] PAYLOAD_LIMIT = 28'd512;

  // fixed header bytes
  localparam logic [3:0] TYPE_PUBLISH   = 4'h3;
  localparam logic [7:0] PUBACK_HEADER  = 8'h40;
  localparam logic [7:0] PUBACK_REMLEN  = 8'h02;
  localparam logic [2:0] LEN_BYTES_MAX  = 3'd4;

  // everything one received byte produces, emitted later one result at a time
  typedef struct packed {
    logic        has_byte;
    logic        byte_is_payload;
    logic [7:0]  byte_val;
    logic        has_drop;
    logic [2:0]  reason;
    logic        has_done;
    logic        qos_class;
    logic [15:0] packet_id;
    logic [8:0]  payload_length;
    logic        has_ack;
  } res_desc_t;

endpackage

// File: rtl/core/mqtt_publish_receive_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_publish_receive_parser
// Parses received MQTT 3.1.1 bytes, streams PUBLISH topic and payload bytes,
// reports message completion, PUBACK bytes and drops with a reason.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid, in_ready  | rx_byte
//  output  | out_valid, out_ready| kind, data, qos_class, packet_id,
//          |                     | payload_length, last
//
//  One byte is parsed per cycle; the parse state updates at the accepting edge
//  and the byte's results land in a two-entry descriptor queue.
//  A byte with no result uses no queue entry; a byte with n results holds
//  one entry until all are taken (at most six: byte, done and 4 PUBACK bytes).
//  in_ready drops only when both queue entries are occupied.
//  rst is synchronous and returns the parser to waiting for a packet type byte.
//
module mqtt_publish_receive_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data,
  output logic        qos_class,
  output logic [15:0] packet_id,
  output logic [8:0]  payload_length,
  output logic        last
);

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_LEN_OTHER,
    PH_LEN_PUB,
    PH_SKIP,
    PH_TOPIC_HI,
    PH_TOPIC_LO,
    PH_TOPIC,
    PH_ID_HI,
    PH_ID_LO,
    PH_PAYLOAD
  } phase_t;

  // parse state
  phase_t      phase, phase_next;
  logic [1:0]  qos_level, qos_level_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [15:0] topic_size, topic_size_next;
  logic [15:0] field_count, field_count_next;
  logic [15:0] ident, ident_next;
  logic [8:0]  body_size, body_size_next;

  mqtt_prp_pkg::res_desc_t desc;
  logic                    desc_any;

  // descriptor queue
  mqtt_prp_pkg::res_desc_t desc_q [2];
  mqtt_prp_pkg::res_desc_t head;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic [2:0] step;
  logic       accept, push, pop;

  // length group shifted into place
  logic [27:0] len_group;
  always_comb begin
    unique case (length_byte_count[1:0])
      2'd0:    len_group = {21'd0, rx_byte[6:0]};
      2'd1:    len_group = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_group = {7'd0, rx_byte[6:0], 14'd0};
      default: len_group = {rx_byte[6:0], 21'd0};
    endcase
  end

  // parse one byte: next state and result descriptor
  always_comb begin
    logic       go_after, go_payload, go_finish, go_drop, go_skip;
    logic [2:0] reason;
    go_after               = 1'b0;
    go_payload             = 1'b0;
    go_finish              = 1'b0;
    go_drop                = 1'b0;
    go_skip                = 1'b0;
    reason                 = mqtt_prp_pkg::DROP_MALFORMED;
    phase_next             = phase;
    qos_level_next         = qos_level;
    bytes_left_next        = bytes_left;
    length_byte_count_next = length_byte_count;
    topic_size_next        = topic_size;
    field_count_next       = field_count;
    ident_next             = ident;
    body_size_next         = body_size;
    desc                   = '0;

    unique case (phase)
      PH_LEN_OTHER, PH_LEN_PUB: begin
        bytes_left_next        = bytes_left + len_group;
        length_byte_count_next = length_byte_count + 3'd1;
        if (rx_byte[7]) begin
          if (length_byte_count_next >= mqtt_prp_pkg::LEN_BYTES_MAX) begin
            bytes_left_next = '0;
            go_drop         = 1'b1;
            reason          = mqtt_prp_pkg::DROP_MALFORMED;
          end
        end else if (phase == PH_LEN_PUB) begin
          if (bytes_left_next < 28'd2) begin
            go_drop = 1'b1;
            reason  = mqtt_prp_pkg::DROP_SHORT;
          end else begin
            phase_next = PH_TOPIC_HI;
          end
        end else begin
          go_skip = 1'b1;
        end
      end
      PH_SKIP: begin
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - 28'd1;
        end
        if (bytes_left_next == '0) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TOPIC_HI: begin
        topic_size_next = {rx_byte, 8'd0};
        bytes_left_next = bytes_left - 28'd1;
        phase_next      = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        topic_size_next = {topic_size[15:8], rx_byte};
        bytes_left_next = bytes_left - 28'd1;
        if ({1'b0, topic_size_next} >= mqtt_prp_pkg::TOPIC_LIMIT) begin
          go_drop = 1'b1;
          reason  = mqtt_prp_pkg::DROP_TOPIC_LONG;
        end else if (bytes_left_next < {12'd0, topic_size_next}) begin
          go_drop = 1'b1;
          reason  = mqtt_prp_pkg::DROP_SHORT;
        end else begin
          field_count_next = '0;
          if (topic_size_next == '0) begin
            go_after = 1'b1;
          end else begin
            phase_next = PH_TOPIC;
          end
        end
      end
      PH_TOPIC: begin
        desc.has_byte        = 1'b1;
        desc.byte_is_payload = 1'b0;
        desc.byte_val        = rx_byte;
        field_count_next     = field_count + 16'd1;
        bytes_left_next      = bytes_left - 28'd1;
        if (field_count_next == topic_size) begin
          go_after = 1'b1;
        end
      end
      PH_ID_HI: begin
        ident_next      = {rx_byte, 8'd0};
        bytes_left_next = bytes_left - 28'd1;
        phase_next      = PH_ID_LO;
      end
      PH_ID_LO: begin
        ident_next      = {ident[15:8], rx_byte};
        bytes_left_next = bytes_left - 28'd1;
        go_payload      = 1'b1;
      end
      PH_PAYLOAD: begin
        desc.has_byte        = 1'b1;
        desc.byte_is_payload = 1'b1;
        desc.byte_val        = rx_byte;
        bytes_left_next      = bytes_left - 28'd1;
        if (bytes_left_next == '0) begin
          go_finish = 1'b1;
        end
      end
      default: begin
        // packet type byte
        qos_level_next         = rx_byte[2:1];
        bytes_left_next        = '0;
        length_byte_count_next = '0;
        topic_size_next        = '0;
        field_count_next       = '0;
        ident_next             = '0;
        body_size_next         = '0;
        phase_next = (rx_byte[7:4] == mqtt_prp_pkg::TYPE_PUBLISH) ? PH_LEN_PUB : PH_LEN_OTHER;
      end
    endcase

    // topic done: packet id when qos above zero, else payload
    if (go_after) begin
      if (qos_level != 2'd0) begin
        if (bytes_left_next < 28'd2) begin
          go_drop = 1'b1;
          reason  = mqtt_prp_pkg::DROP_NO_ID;
        end else begin
          phase_next = PH_ID_HI;
        end
      end else begin
        go_payload = 1'b1;
      end
    end

    // payload start
    if (go_payload) begin
      if (bytes_left_next >= mqtt_prp_pkg::PAYLOAD_LIMIT) begin
        go_drop = 1'b1;
        reason  = mqtt_prp_pkg::DROP_PAYLOAD_LONG;
      end else begin
        body_size_next = bytes_left_next[8:0];
        if (bytes_left_next == '0) begin
          go_finish = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end

    // message complete, with puback for qos 1 and a nonzero id
    if (go_finish) begin
      desc.has_done       = 1'b1;
      desc.qos_class      = (qos_level != 2'd0);
      desc.packet_id      = ident_next;
      desc.payload_length = body_size_next;
      desc.has_ack        = (qos_level == 2'd1) && (ident_next != '0);
      phase_next          = PH_TYPE;
    end

    if (go_drop) begin
      desc.has_drop = 1'b1;
      desc.reason   = reason;
      go_skip       = 1'b1;
    end

    // skip the rest of the packet
    if (go_skip) begin
      phase_next = (bytes_left_next == '0) ? PH_TYPE : PH_SKIP;
    end
  end

  assign desc_any = desc.has_byte | desc.has_drop | desc.has_done;

  // handshakes
  assign in_ready  = (count != 2'd2);
  assign accept    = in_valid & in_ready;
  assign push      = accept & desc_any;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid & out_ready & last;
  assign head      = desc_q[rd_ptr];

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TYPE;
      qos_level         <= '0;
      bytes_left        <= '0;
      length_byte_count <= '0;
      topic_size        <= '0;
      field_count       <= '0;
      ident             <= '0;
      body_size         <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      qos_level         <= qos_level_next;
      bytes_left        <= bytes_left_next;
      length_byte_count <= length_byte_count_next;
      topic_size        <= topic_size_next;
      field_count       <= field_count_next;
      ident             <= ident_next;
      body_size         <= body_size_next;
    end
  end

  // descriptor queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[wr_ptr] <= desc;
    end
  end

  // queue pointers and result step within the head descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      step   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        step   <= '0;
      end else if (out_valid && out_ready) begin
        step <= step + 3'd1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // result selection from the head descriptor
  logic [2:0] res_total;
  logic [2:0] sub;
  always_comb begin
    res_total = {2'd0, head.has_byte} + {2'd0, head.has_drop | head.has_done}
              + (head.has_ack ? 3'd4 : 3'd0);
    sub            = step - {2'd0, head.has_byte};
    kind           = mqtt_prp_pkg::KIND_ACK;
    data           = '0;
    qos_class      = 1'b0;
    packet_id      = '0;
    payload_length = '0;
    last           = (step == res_total - 3'd1);
    if (head.has_byte && step == 3'd0) begin
      kind = head.byte_is_payload ? mqtt_prp_pkg::KIND_PAYLOAD : mqtt_prp_pkg::KIND_TOPIC;
      data = head.byte_val;
    end else if (sub == 3'd0) begin
      if (head.has_drop) begin
        kind = mqtt_prp_pkg::KIND_DROP;
        data = {5'd0, head.reason};
      end else begin
        kind           = mqtt_prp_pkg::KIND_DONE;
        qos_class      = head.qos_class;
        packet_id      = head.packet_id;
        payload_length = head.payload_length;
      end
    end else begin
      unique case (sub)
        3'd1:    data = mqtt_prp_pkg::PUBACK_HEADER;
        3'd2:    data = mqtt_prp_pkg::PUBACK_REMLEN;
        3'd3:    data = head.packet_id[15:8];
        default: data = head.packet_id[7:0];
      endcase
    end
  end

`ifndef SYNTHESIS
  // queue never holds more than two descriptors
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("descriptor queue overflow");

  // the result step stays inside the head descriptor's result list
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step < res_total))
    else $error("result step beyond descriptor");

  // skipping always has bytes left to consume
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> bytes_left != '0)
    else $error("skip phase with nothing left");

  // a descriptor pushed while the queue is empty is shown in the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (out_valid && step == 3'd0))
    else $error("pushed descriptor not presented");

  // the result step holds while the output is stalled
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(step))
    else $error("result step moved while stalled");
`endif

endmodule
